// ===== sv/erbp_pkg.sv =====
// ----------------------------------------------------------------------------
// Exposure record byte parser package
// Shared types, field tags, record positions and decode helpers.
// ----------------------------------------------------------------------------
`default_nettype none

package erbp_pkg;

  localparam int NOTE_LENGTH_DEFAULT = 32;
  localparam int MAX_RESULTS = 4;
  localparam int QUEUE_DEPTH = 8;

  localparam logic [4:0] TAG_FRAME      = 5'd0;
  localparam logic [4:0] TAG_FILM       = 5'd1;
  localparam logic [4:0] TAG_SHUTTER    = 5'd2;
  localparam logic [4:0] TAG_APERTURE   = 5'd3;
  localparam logic [4:0] TAG_MODE       = 5'd4;
  localparam logic [4:0] TAG_FOCAL      = 5'd5;
  localparam logic [4:0] TAG_FLASH      = 5'd6;
  localparam logic [4:0] TAG_METERING   = 5'd7;
  localparam logic [4:0] TAG_AV_OVR     = 5'd8;
  localparam logic [4:0] TAG_TV_OVR     = 5'd9;
  localparam logic [4:0] TAG_ISO        = 5'd10;
  localparam logic [4:0] TAG_YEAR       = 5'd11;
  localparam logic [4:0] TAG_MONTH      = 5'd12;
  localparam logic [4:0] TAG_DAY        = 5'd13;
  localparam logic [4:0] TAG_HOUR       = 5'd14;
  localparam logic [4:0] TAG_MINUTE     = 5'd15;
  localparam logic [4:0] TAG_SECOND     = 5'd16;
  localparam logic [4:0] TAG_LENS_AV    = 5'd17;
  localparam logic [4:0] TAG_BRACKET    = 5'd18;
  localparam logic [4:0] TAG_CORRECTION = 5'd19;
  localparam logic [4:0] TAG_MULTI_EXP  = 5'd20;
  localparam logic [4:0] TAG_LENS_LOW   = 5'd21;
  localparam logic [4:0] TAG_LENS_HIGH  = 5'd22;
  localparam logic [4:0] TAG_NOTE_CHAR  = 5'd23;
  localparam logic [4:0] TAG_REC_END    = 5'd24;
  localparam logic [4:0] TAG_DATA_END   = 5'd25;

  localparam logic [4:0] POS_START = 5'd0;
  localparam logic [4:0] POS_FLASH = 5'd7;
  localparam logic [4:0] POS_FLAGS = 5'd16;
  localparam logic [4:0] POS_CORR  = 5'd17;
  localparam logic [4:0] POS_ME    = 5'd18;
  localparam logic [4:0] POS_LENS  = 5'd19;
  localparam logic [4:0] POS_NOTE  = 5'd23;
  localparam logic [4:0] POS_SKIP  = 5'd24;

  localparam logic [7:0] END_BYTE = 8'hFF;

  typedef struct packed {
    logic [4:0]         tag;
    logic signed [16:0] value;
    logic               short_rec;
    logic               last;
  } result_t;

  typedef struct packed {
    logic [2:0]         count;
    result_t [3:0]      item;
  } push_t;

  function automatic logic [7:0] bcd(input logic [7:0] b);
    logic [7:0] hi;
    hi = {4'd0, b[7:4]};
    return (hi << 3) + (hi << 1) + {4'd0, b[3:0]};
  endfunction

  function automatic logic [7:0] remap(input logic [7:0] c);
    logic [7:0] r;
    case (c)
      8'hE0:   r = 8'h8E;
      8'hE4:   r = 8'h99;
      8'hE6:   r = 8'h9A;
      default: r = c;
    endcase
    return r;
  endfunction

  function automatic result_t mk(input logic [4:0] tag, input logic signed [16:0] value,
                                 input logic short_rec);
    result_t r;
    r.tag = tag;
    r.value = value;
    r.short_rec = short_rec;
    r.last = 1'b0;
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== sv/erbp_decoder.sv =====
// ----------------------------------------------------------------------------
// Exposure record decoder
// Holds the record state and turns one byte into up to four tagged results.
// ----------------------------------------------------------------------------
`default_nettype none

module erbp_decoder #(
  parameter int NOTE_LENGTH = erbp_pkg::NOTE_LENGTH_DEFAULT
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cfg_we,
  input  wire logic signed [14:0] cfg_wdata,
  input  wire logic               accept,
  input  wire logic [7:0]         data_byte,
  input  wire logic               end_of_file,
  output erbp_pkg::push_t         push
);

  logic signed [14:0] film_number_offset;
  logic [4:0]         byte_position, byte_position_next;
  logic [7:0]         option_flags, option_flags_next;
  logic               flash_low_bit, flash_low_bit_next;
  logic [3:0]         film_hundreds, film_hundreds_next;
  logic [7:0]         high_byte_hold, high_byte_hold_next;
  logic [7:0]         note_count, note_count_next;
  logic               note_stopped, note_stopped_next;
  logic               data_done, data_done_next;

  function automatic logic [4:0] next_section(input logic [4:0] p, input logic [7:0] f);
    logic [4:0] r;
    if (p <= erbp_pkg::POS_CORR && f[5]) begin
      r = erbp_pkg::POS_CORR;
    end else if (p <= erbp_pkg::POS_ME && f[4]) begin
      r = erbp_pkg::POS_ME;
    end else if (p <= erbp_pkg::POS_LENS && f[2]) begin
      r = erbp_pkg::POS_LENS;
    end else if (p <= erbp_pkg::POS_NOTE && f[1]) begin
      r = erbp_pkg::POS_NOTE;
    end else begin
      r = erbp_pkg::POS_SKIP;
    end
    return r;
  endfunction

  always_comb begin
    logic [2:0]         n;
    logic [7:0]         b;
    logic [7:0]         bv;
    logic [10:0]        h100;
    logic signed [16:0] film;
    logic [11:0]        year;
    logic               stop_v;
    logic [7:0]         cnt;
    b = data_byte;
    bv = erbp_pkg::bcd(data_byte);
    h100 = {1'b0, film_hundreds, 6'd0} + {2'b0, film_hundreds, 5'd0}
         + {5'd0, film_hundreds, 2'd0};
    film = $signed({6'd0, h100}) + $signed({9'd0, bv})
         + $signed({{2{film_number_offset[14]}}, film_number_offset});
    year = (bv < 8'd80) ? (12'd2000 + {4'd0, bv}) : (12'd1900 + {4'd0, bv});
    stop_v = note_stopped | (b == 8'd0);
    cnt = note_count + 8'd1;
    n = 3'd0;
    push.item = '0;
    byte_position_next = byte_position;
    option_flags_next = option_flags;
    flash_low_bit_next = flash_low_bit;
    film_hundreds_next = film_hundreds;
    high_byte_hold_next = high_byte_hold;
    note_count_next = note_count;
    note_stopped_next = note_stopped;
    data_done_next = data_done;

    if (accept && !data_done) begin
      if (end_of_file) begin
        if (byte_position != erbp_pkg::POS_START) begin
          if (byte_position == erbp_pkg::POS_FLASH) begin
            push.item[n[1:0]] = erbp_pkg::mk(erbp_pkg::TAG_FLASH,
                                             {16'd0, flash_low_bit}, 1'b0);
            n = n + 3'd1;
          end
          push.item[n[1:0]] = erbp_pkg::mk(erbp_pkg::TAG_REC_END, '0,
                                           byte_position <= erbp_pkg::POS_FLASH);
          n = n + 3'd1;
        end
        push.item[n[1:0]] = erbp_pkg::mk(erbp_pkg::TAG_DATA_END, '0, 1'b0);
        n = n + 3'd1;
        byte_position_next = erbp_pkg::POS_START;
        data_done_next = 1'b1;
      end else begin
        byte_position_next = byte_position + 5'd1;
        case (byte_position)
          erbp_pkg::POS_START: begin
            if (b == erbp_pkg::END_BYTE) begin
              push.item[0] = erbp_pkg::mk(erbp_pkg::TAG_DATA_END, '0, 1'b0);
              n = 3'd1;
              data_done_next = 1'b1;
              byte_position_next = erbp_pkg::POS_START;
            end else begin
              option_flags_next = 8'd0;
              flash_low_bit_next = 1'b0;
              high_byte_hold_next = 8'd0;
              push.item[0] = erbp_pkg::mk(erbp_pkg::TAG_FRAME, {9'd0, bv}, 1'b0);
              n = 3'd1;
            end
          end
          5'd1: film_hundreds_next = b[3:0];
          5'd2: begin
            push.item[0] = erbp_pkg::mk(erbp_pkg::TAG_FILM, film, 1'b0);
            n = 3'd1;
          end
          5'd3: begin
            flash_low_bit_next = b[0];
            push.item[0] = erbp_pkg::mk(erbp_pkg::TAG_SHUTTER, {9'd0, b & 8'hFC}, 1'b0);
            n = 3'd1;
          end
          5'd4: begin
            push.item[0] = erbp_pkg::mk(erbp_pkg::TAG_APERTURE, {9'd0, b & 8'h7C}, 1'b0);
            push.item[1] = erbp_pkg::mk(erbp_pkg::TAG_MODE, {9'd0, b & 8'h83}, 1'b0);
            n = 3'd2;
          end
          5'd5, erbp_pkg::POS_LENS, 5'd21: high_byte_hold_next = b;
          5'd6: begin
            push.item[0] = erbp_pkg::mk(erbp_pkg::TAG_FOCAL, {1'b0, high_byte_hold, b}, 1'b0);
            n = 3'd1;
          end
          erbp_pkg::POS_FLASH: begin
            if (b == erbp_pkg::END_BYTE) begin
              push.item[0] = erbp_pkg::mk(erbp_pkg::TAG_FLASH, {16'd0, flash_low_bit}, 1'b0);
              push.item[1] = erbp_pkg::mk(erbp_pkg::TAG_REC_END, '0, 1'b1);
              n = 3'd2;
              byte_position_next = erbp_pkg::POS_START;
            end else begin
              push.item[0] = erbp_pkg::mk(erbp_pkg::TAG_FLASH,
                                          {9'd0, (b & 8'h8E) | {7'd0, flash_low_bit}}, 1'b0);
              push.item[1] = erbp_pkg::mk(erbp_pkg::TAG_METERING, {9'd0, b & 8'h11}, 1'b0);
              push.item[2] = erbp_pkg::mk(erbp_pkg::TAG_AV_OVR, {9'd0, b & 8'h20}, 1'b0);
              push.item[3] = erbp_pkg::mk(erbp_pkg::TAG_TV_OVR, {9'd0, b & 8'h40}, 1'b0);
              n = 3'd4;
            end
          end
          5'd8: begin
            push.item[0] = erbp_pkg::mk(erbp_pkg::TAG_ISO, {9'd0, b & 8'hFE}, 1'b0);
            n = 3'd1;
          end
          5'd9: begin
            push.item[0] = erbp_pkg::mk(erbp_pkg::TAG_YEAR, {5'd0, year}, 1'b0);
            n = 3'd1;
          end
          5'd10: begin
            push.item[0] = erbp_pkg::mk(erbp_pkg::TAG_MONTH, {9'd0, bv}, 1'b0);
            n = 3'd1;
          end
          5'd11: begin
            push.item[0] = erbp_pkg::mk(erbp_pkg::TAG_DAY, {9'd0, bv}, 1'b0);
            n = 3'd1;
          end
          5'd12: begin
            push.item[0] = erbp_pkg::mk(erbp_pkg::TAG_HOUR, {9'd0, b}, 1'b0);
            n = 3'd1;
          end
          5'd13: begin
            push.item[0] = erbp_pkg::mk(erbp_pkg::TAG_MINUTE, {9'd0, b}, 1'b0);
            n = 3'd1;
          end
          5'd14: begin
            push.item[0] = erbp_pkg::mk(erbp_pkg::TAG_SECOND, {9'd0, b}, 1'b0);
            n = 3'd1;
          end
          5'd15: begin
            push.item[0] = erbp_pkg::mk(erbp_pkg::TAG_LENS_AV, {9'd0, b & 8'h7C}, 1'b0);
            n = 3'd1;
          end
          erbp_pkg::POS_FLAGS: begin
            option_flags_next = b;
            push.item[0] = erbp_pkg::mk(erbp_pkg::TAG_BRACKET, {16'd0, b[0]}, 1'b0);
            n = 3'd1;
            byte_position_next = next_section(erbp_pkg::POS_CORR, b);
          end
          erbp_pkg::POS_CORR: begin
            push.item[0] = erbp_pkg::mk(erbp_pkg::TAG_CORRECTION, {9'd0, b}, 1'b0);
            n = 3'd1;
            byte_position_next = next_section(erbp_pkg::POS_ME, option_flags);
          end
          erbp_pkg::POS_ME: begin
            push.item[0] = erbp_pkg::mk(erbp_pkg::TAG_MULTI_EXP, {9'd0, bv}, 1'b0);
            n = 3'd1;
            byte_position_next = next_section(erbp_pkg::POS_LENS, option_flags);
          end
          5'd20: begin
            push.item[0] = erbp_pkg::mk(erbp_pkg::TAG_LENS_LOW,
                                        {1'b0, high_byte_hold, b}, 1'b0);
            n = 3'd1;
          end
          5'd22: begin
            push.item[0] = erbp_pkg::mk(erbp_pkg::TAG_LENS_HIGH,
                                        {1'b0, high_byte_hold, b}, 1'b0);
            n = 3'd1;
            byte_position_next = next_section(erbp_pkg::POS_NOTE, option_flags);
          end
          erbp_pkg::POS_NOTE: begin
            if (b == erbp_pkg::END_BYTE) begin
              push.item[0] = erbp_pkg::mk(erbp_pkg::TAG_REC_END, '0, 1'b0);
              n = 3'd1;
              byte_position_next = erbp_pkg::POS_START;
            end else begin
              note_stopped_next = stop_v;
              if (!stop_v) begin
                push.item[0] = erbp_pkg::mk(erbp_pkg::TAG_NOTE_CHAR,
                                            {9'd0, erbp_pkg::remap(b)}, 1'b0);
                n = 3'd1;
              end
              note_count_next = cnt;
              byte_position_next = (cnt >= 8'(NOTE_LENGTH)) ? erbp_pkg::POS_SKIP
                                                            : erbp_pkg::POS_NOTE;
            end
          end
          default: begin
            if (b == erbp_pkg::END_BYTE) begin
              push.item[0] = erbp_pkg::mk(erbp_pkg::TAG_REC_END, '0, 1'b0);
              n = 3'd1;
              byte_position_next = erbp_pkg::POS_START;
            end else begin
              byte_position_next = erbp_pkg::POS_SKIP;
            end
          end
        endcase
        if (byte_position_next == erbp_pkg::POS_NOTE && byte_position != erbp_pkg::POS_NOTE) begin
          note_count_next = 8'd0;
          note_stopped_next = 1'b0;
        end
      end
    end
    if (n != 3'd0) begin
      push.item[2'(n - 3'd1)].last = 1'b1;
    end
    push.count = n;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      film_number_offset <= '0;
      byte_position <= erbp_pkg::POS_START;
      option_flags <= '0;
      flash_low_bit <= 1'b0;
      film_hundreds <= '0;
      high_byte_hold <= '0;
      note_count <= '0;
      note_stopped <= 1'b0;
      data_done <= 1'b0;
    end else begin
      if (cfg_we) begin
        film_number_offset <= cfg_wdata;
      end
      byte_position <= byte_position_next;
      option_flags <= option_flags_next;
      flash_low_bit <= flash_low_bit_next;
      film_hundreds <= film_hundreds_next;
      high_byte_hold <= high_byte_hold_next;
      note_count <= note_count_next;
      note_stopped <= note_stopped_next;
      data_done <= data_done_next;
    end
  end

endmodule

`default_nettype wire

// ===== sv/erbp_queue.sv =====
// ----------------------------------------------------------------------------
// Result queue
// Takes up to four results a cycle and hands them out one at a time.
// ----------------------------------------------------------------------------
`default_nettype none

module erbp_queue (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire erbp_pkg::push_t   push,
  input  wire logic              pop,
  output logic                   full,
  output logic                   not_empty,
  output erbp_pkg::result_t      head
);

  localparam int DEPTH = erbp_pkg::QUEUE_DEPTH;
  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  erbp_pkg::result_t mem [DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [CNT_W-1:0]  count;

  assign not_empty = (count != '0);
  assign full = (count > CNT_W'(DEPTH - erbp_pkg::MAX_RESULTS));
  assign head = mem[rd_ptr];

  always_ff @(posedge clk) begin
    for (int k = 0; k < erbp_pkg::MAX_RESULTS; k++) begin
      if (3'(k) < push.count) begin
        mem[wr_ptr + PTR_W'(k)] <= push.item[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      wr_ptr <= wr_ptr + PTR_W'(push.count);
      rd_ptr <= rd_ptr + PTR_W'(pop);
      count <= count + CNT_W'(push.count) - CNT_W'(pop);
    end
  end

endmodule

`default_nettype wire

// ===== sv/exposure_record_byte_parser.sv =====
// ----------------------------------------------------------------------------
// Exposure record byte parser
// Parses an exposure record byte stream into tagged field words.
//
//   Channel  Direction  Handshake           Payload
//   input    in         in_valid/in_stall   data_byte, end_of_file
//   output   out        out_valid/out_stall field_tag, field_value,
//                                           short_record, last_of_run
//   config   in         cfg_we              cfg_wdata
//
// One byte is accepted per cycle while in_stall is low; it is decoded in
// the same cycle into zero to four results that are written into an
// eight-entry queue. Results leave the queue one per cycle while out_stall
// is low. in_stall is high while fewer than four queue entries are free.
// Synchronous reset clears the record state, the offset and the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module exposure_record_byte_parser #(
  parameter int NOTE_LENGTH = erbp_pkg::NOTE_LENGTH_DEFAULT
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cfg_we,
  input  wire logic signed [14:0] cfg_wdata,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [7:0]         data_byte,
  input  wire logic               end_of_file,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic [4:0]              field_tag,
  output logic signed [16:0]      field_value,
  output logic                    short_record,
  output logic                    last_of_run
);

  erbp_pkg::push_t   push;
  erbp_pkg::result_t head;
  logic              accept;

  assign accept = in_valid && !in_stall;

  erbp_decoder #(
    .NOTE_LENGTH(NOTE_LENGTH)
  ) u_decoder (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .accept     (accept),
    .data_byte  (data_byte),
    .end_of_file(end_of_file),
    .push       (push)
  );

  erbp_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .pop      (out_valid && !out_stall),
    .full     (in_stall),
    .not_empty(out_valid),
    .head     (head)
  );

  assign field_tag = head.tag;
  assign field_value = head.value;
  assign short_record = head.short_rec;
  assign last_of_run = head.last;

endmodule

`default_nettype wire

// ===== sv/erbp_checker.sv =====
// ----------------------------------------------------------------------------
// Exposure record parser checker
// Port-level properties of the parser, bound to its top level.
// ----------------------------------------------------------------------------
`default_nettype none

module erbp_checker (
  input wire logic               clk,
  input wire logic               rst,
  input wire logic               cfg_we,
  input wire logic signed [14:0] cfg_wdata,
  input wire logic               in_valid,
  input wire logic               in_stall,
  input wire logic [7:0]         data_byte,
  input wire logic               end_of_file,
  input wire logic               out_valid,
  input wire logic               out_stall,
  input wire logic [4:0]         field_tag,
  input wire logic signed [16:0] field_value,
  input wire logic               short_record,
  input wire logic               last_of_run
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(field_tag) && $stable(field_value)
      && $stable(short_record) && $stable(last_of_run))
    else $error("Stalled result changed.");

  a_short_on_end: assert property (@(posedge clk) disable iff (rst)
    out_valid && short_record |-> field_tag == erbp_pkg::TAG_REC_END)
    else $error("Short record flag on a non-end tag.");

  a_end_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && (field_tag == erbp_pkg::TAG_REC_END || field_tag == erbp_pkg::TAG_DATA_END)
      |-> field_value == '0 && last_of_run == (field_tag == erbp_pkg::TAG_DATA_END
      || last_of_run))
    else $error("End tag carries a value.");

  a_reset_clear: assert property (@(posedge clk)
    rst |=> !in_stall && !out_valid)
    else $error("Queue not empty after reset.");

endmodule

bind exposure_record_byte_parser erbp_checker u_erbp_checker (.*);

`default_nettype wire

// ===== sim/exposure_record_byte_parser_test.sv =====
// ----------------------------------------------------------------------------
// Exposure record byte parser testbench
// Drives exposure record streams into the parser and checks every field word
// against a predictor of the record decode. A short directed opening covers
// the field extremes, short records, optional sections and note handling.
// Random records follow under several film number offsets. The run ends with
// an end of data and a few ignored words. Both channels idle at random.
// ----------------------------------------------------------------------------

module exposure_record_byte_parser_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NOTE_LEN = erbp_pkg::NOTE_LENGTH_DEFAULT;
  localparam int CYCLE_LIMIT = 300000;

  typedef struct {
    logic [7:0] data;
    logic       eof;
    logic       drain_first;
  } stream_word_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               cfg_we = 1'b0;
  logic signed [14:0] cfg_wdata = '0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [7:0]         data_byte = '0;
  logic               end_of_file = 1'b0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [4:0]         field_tag;
  logic signed [16:0] field_value;
  logic               short_record;
  logic               last_of_run;

  stream_word_t      stream_words[$];
  erbp_pkg::result_t expected_fields[$];
  logic [7:0]        rec_bytes[$];

  logic       drain_next = 1'b0;
  logic       in_gaps = 1'b1;
  logic       out_gaps = 1'b1;
  logic       byte_taken = 1'b0;
  int         gap_left = 0;
  int         stall_left = 0;
  int         words_planned = 0;
  int         words_sent = 0;
  int         fields_checked = 0;
  int         records_seen = 0;
  int         offsets_written = 0;
  int         error_count = 0;
  int         cycle_count = 0;

  int         film_offset = 0;
  logic [4:0] rec_pos = erbp_pkg::POS_START;
  logic [7:0] opt_flags = '0;
  logic       flash_bit = 1'b0;
  int         film_hund = 0;
  logic [7:0] hi_hold = '0;
  logic [7:0] note_cnt = '0;
  logic       note_off = 1'b0;
  logic       data_done = 1'b0;

  exposure_record_byte_parser dut (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_wdata(cfg_wdata),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .data_byte(data_byte),
    .end_of_file(end_of_file),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .field_tag(field_tag),
    .field_value(field_value),
    .short_record(short_record),
    .last_of_run(last_of_run)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  task automatic report_error(input string msg);
    error_count++;
    if (error_count <= 40) $display("mismatch at cycle %0d: %s", cycle_count, msg);
  endtask

  function automatic int bcd_value(input logic [7:0] b);
    return int'(b[7:4]) * 10 + int'(b[3:0]);
  endfunction

  function automatic void add_field(input logic [4:0] tag, input int value, input logic shrt);
    erbp_pkg::result_t r;
    r.tag = tag;
    r.value = 17'(value);
    r.short_rec = shrt;
    r.last = 1'b0;
    expected_fields.push_back(r);
  endfunction

  function automatic logic [4:0] next_part(input logic [4:0] from);
    if (from <= erbp_pkg::POS_CORR && opt_flags[5]) return erbp_pkg::POS_CORR;
    if (from <= erbp_pkg::POS_ME && opt_flags[4]) return erbp_pkg::POS_ME;
    if (from <= erbp_pkg::POS_LENS && opt_flags[2]) return erbp_pkg::POS_LENS;
    if (from <= erbp_pkg::POS_NOTE && opt_flags[1]) begin
      note_cnt = '0;
      note_off = 1'b0;
      return erbp_pkg::POS_NOTE;
    end
    return erbp_pkg::POS_SKIP;
  endfunction

  function automatic void decode_stream_word(input logic [7:0] b, input logic eof);
    int         first;
    int         yr;
    logic [4:0] nxt;
    logic [7:0] ch;
    first = expected_fields.size();
    if (data_done) return;
    if (eof) begin
      if (rec_pos != erbp_pkg::POS_START) begin
        if (rec_pos == erbp_pkg::POS_FLASH)
          add_field(erbp_pkg::TAG_FLASH, int'(flash_bit), 1'b0);
        add_field(erbp_pkg::TAG_REC_END, 0, rec_pos <= erbp_pkg::POS_FLASH);
      end
      add_field(erbp_pkg::TAG_DATA_END, 0, 1'b0);
      rec_pos = erbp_pkg::POS_START;
      data_done = 1'b1;
    end else begin
      nxt = rec_pos + 5'd1;
      case (rec_pos)
        erbp_pkg::POS_START: begin
          if (b == erbp_pkg::END_BYTE) begin
            add_field(erbp_pkg::TAG_DATA_END, 0, 1'b0);
            data_done = 1'b1;
            nxt = erbp_pkg::POS_START;
          end else begin
            opt_flags = '0;
            flash_bit = 1'b0;
            hi_hold = '0;
            add_field(erbp_pkg::TAG_FRAME, bcd_value(b), 1'b0);
          end
        end
        1: film_hund = int'(b[3:0]) * 100;
        2: add_field(erbp_pkg::TAG_FILM, film_hund + bcd_value(b) + film_offset, 1'b0);
        3: begin
          flash_bit = b[0];
          add_field(erbp_pkg::TAG_SHUTTER, int'(b & 8'hFC), 1'b0);
        end
        4: begin
          add_field(erbp_pkg::TAG_APERTURE, int'(b & 8'h7C), 1'b0);
          add_field(erbp_pkg::TAG_MODE, int'(b & 8'h83), 1'b0);
        end
        5, erbp_pkg::POS_LENS, erbp_pkg::POS_LENS + 5'd2: hi_hold = b;
        6: add_field(erbp_pkg::TAG_FOCAL, int'({hi_hold, b}), 1'b0);
        erbp_pkg::POS_FLASH: begin
          if (b == erbp_pkg::END_BYTE) begin
            add_field(erbp_pkg::TAG_FLASH, int'(flash_bit), 1'b0);
            add_field(erbp_pkg::TAG_REC_END, 0, 1'b1);
            nxt = erbp_pkg::POS_START;
          end else begin
            add_field(erbp_pkg::TAG_FLASH, int'({7'd0, flash_bit} | (b & 8'h8E)), 1'b0);
            add_field(erbp_pkg::TAG_METERING, int'(b & 8'h11), 1'b0);
            add_field(erbp_pkg::TAG_AV_OVR, int'(b & 8'h20), 1'b0);
            add_field(erbp_pkg::TAG_TV_OVR, int'(b & 8'h40), 1'b0);
          end
        end
        8: add_field(erbp_pkg::TAG_ISO, int'(b & 8'hFE), 1'b0);
        9: begin
          yr = bcd_value(b) + 1900;
          if (yr < 1980) yr += 100;
          add_field(erbp_pkg::TAG_YEAR, yr, 1'b0);
        end
        10: add_field(erbp_pkg::TAG_MONTH, bcd_value(b), 1'b0);
        11: add_field(erbp_pkg::TAG_DAY, bcd_value(b), 1'b0);
        12: add_field(erbp_pkg::TAG_HOUR, int'(b), 1'b0);
        13: add_field(erbp_pkg::TAG_MINUTE, int'(b), 1'b0);
        14: add_field(erbp_pkg::TAG_SECOND, int'(b), 1'b0);
        15: add_field(erbp_pkg::TAG_LENS_AV, int'(b & 8'h7C), 1'b0);
        erbp_pkg::POS_FLAGS: begin
          opt_flags = b;
          add_field(erbp_pkg::TAG_BRACKET, int'(b[0]), 1'b0);
          nxt = next_part(erbp_pkg::POS_CORR);
        end
        erbp_pkg::POS_CORR: begin
          add_field(erbp_pkg::TAG_CORRECTION, int'(b), 1'b0);
          nxt = next_part(erbp_pkg::POS_ME);
        end
        erbp_pkg::POS_ME: begin
          add_field(erbp_pkg::TAG_MULTI_EXP, bcd_value(b), 1'b0);
          nxt = next_part(erbp_pkg::POS_LENS);
        end
        erbp_pkg::POS_LENS + 5'd1:
          add_field(erbp_pkg::TAG_LENS_LOW, int'({hi_hold, b}), 1'b0);
        erbp_pkg::POS_LENS + 5'd3: begin
          add_field(erbp_pkg::TAG_LENS_HIGH, int'({hi_hold, b}), 1'b0);
          nxt = next_part(erbp_pkg::POS_NOTE);
        end
        erbp_pkg::POS_NOTE: begin
          if (b == erbp_pkg::END_BYTE) begin
            add_field(erbp_pkg::TAG_REC_END, 0, 1'b0);
            nxt = erbp_pkg::POS_START;
          end else begin
            if (b == 8'h00) note_off = 1'b1;
            if (!note_off) begin
              case (b)
                8'hE0:   ch = 8'h8E;
                8'hE4:   ch = 8'h99;
                8'hE6:   ch = 8'h9A;
                default: ch = b;
              endcase
              add_field(erbp_pkg::TAG_NOTE_CHAR, int'(ch), 1'b0);
            end
            note_cnt = note_cnt + 8'd1;
            nxt = (int'(note_cnt) >= NOTE_LEN) ? erbp_pkg::POS_SKIP : erbp_pkg::POS_NOTE;
          end
        end
        default: begin
          if (b == erbp_pkg::END_BYTE) begin
            add_field(erbp_pkg::TAG_REC_END, 0, 1'b0);
            nxt = erbp_pkg::POS_START;
          end else begin
            nxt = erbp_pkg::POS_SKIP;
          end
        end
      endcase
      rec_pos = nxt;
    end
    if (expected_fields.size() > first) expected_fields[expected_fields.size() - 1].last = 1'b1;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 2);
    if (r < 96) return $urandom_range(3, 8);
    return $urandom_range(12, 40);
  endfunction

  function automatic logic [7:0] any_but_end();
    return 8'($urandom_range(0, 254));
  endfunction

  function automatic logic [7:0] note_char();
    case ($urandom_range(0, 15))
      0:       return 8'h00;
      1:       return 8'hE0;
      2:       return 8'hE4;
      3:       return 8'hE6;
      default: return 8'($urandom_range(1, 254));
    endcase
  endfunction

  function automatic void put(input logic [7:0] b, input logic eof);
    stream_word_t w;
    w.data = b;
    w.eof = eof;
    w.drain_first = drain_next;
    drain_next = 1'b0;
    stream_words.push_back(w);
    words_planned++;
  endfunction

  function automatic void build_record(input logic allow_short);
    logic [7:0] fl;
    int         n;
    rec_bytes.delete();
    rec_bytes.push_back(any_but_end());
    repeat (6) rec_bytes.push_back(8'($urandom));
    if (allow_short && $urandom_range(0, 3) == 0) begin
      rec_bytes.push_back(erbp_pkg::END_BYTE);
      return;
    end
    rec_bytes.push_back(any_but_end());
    repeat (8) rec_bytes.push_back(8'($urandom));
    fl = 8'($urandom);
    rec_bytes.push_back(fl);
    if (fl[5]) rec_bytes.push_back(8'($urandom));
    if (fl[4]) rec_bytes.push_back(8'($urandom));
    if (fl[2]) repeat (4) rec_bytes.push_back(8'($urandom));
    if (fl[1] && $urandom_range(0, 3) != 0) begin
      n = $urandom_range(0, 8);
      repeat (n) rec_bytes.push_back(note_char());
    end else begin
      if (fl[1]) repeat (NOTE_LEN) rec_bytes.push_back(note_char());
      n = $urandom_range(0, 3);
      repeat (n) rec_bytes.push_back(any_but_end());
    end
    rec_bytes.push_back(erbp_pkg::END_BYTE);
  endfunction

  task automatic queue_records(input int goal);
    while (words_planned < goal) begin
      build_record(1'b1);
      foreach (rec_bytes[i]) put(rec_bytes[i], 1'b0);
    end
  endtask

  task automatic wait_idle();
    do @(posedge clk);
    while (stream_words.size() != 0 || in_valid || expected_fields.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_offset(input logic signed [14:0] v);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    film_offset = int'(v);
    offsets_written++;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  always @(negedge clk) begin
    stream_word_t w;
    if (!rst && (!in_valid || byte_taken)) begin
      if (gap_left != 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (stream_words.size() != 0 &&
                   !(stream_words[0].drain_first && expected_fields.size() != 0)) begin
        w = stream_words.pop_front();
        data_byte <= w.data;
        end_of_file <= w.eof;
        in_valid <= 1'b1;
        gap_left = in_gaps ? pick_gap() : 0;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (stall_left != 0) begin
      out_stall <= 1'b1;
      stall_left--;
    end else begin
      out_stall <= 1'b0;
      if (out_gaps && $urandom_range(0, 3) == 0) stall_left = pick_gap();
    end
  end

  always @(posedge clk) begin
    erbp_pkg::result_t want;
    byte_taken = 1'b0;
    if (!rst) begin
      if (out_valid && !out_stall) begin
        if (expected_fields.size() == 0) begin
          report_error($sformatf("unexpected field word tag %0d value %0d",
                                 field_tag, field_value));
        end else begin
          want = expected_fields.pop_front();
          fields_checked++;
          if (want.tag == erbp_pkg::TAG_REC_END) records_seen++;
          if (field_tag !== want.tag)
            report_error($sformatf("tag %0d, want %0d", field_tag, want.tag));
          if (field_value !== want.value)
            report_error($sformatf("tag %0d value %0d, want %0d",
                                   want.tag, field_value, want.value));
          if (short_record !== want.short_rec)
            report_error($sformatf("tag %0d short_record %b, want %b",
                                   want.tag, short_record, want.short_rec));
          if (last_of_run !== want.last)
            report_error($sformatf("tag %0d last_of_run %b, want %b",
                                   want.tag, last_of_run, want.last));
        end
      end
      if (in_valid && !in_stall) begin
        byte_taken = 1'b1;
        words_sent++;
        decode_stream_word(data_byte, end_of_file);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("exposure_record_byte_parser_test: errors");
      $finish;
    end
  end

  initial begin
    int choice;
    int cut;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Short record with a set shutter bit, then a long record with extreme
    // fields, correction, multiple exposure and a note with umlauts and a stop.
    rec_bytes = '{8'h45, 8'h00, 8'h00, 8'h01, 8'h00, 8'h00, 8'h00, 8'hFF,
                  8'hFE, 8'h0F, 8'h99, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFE,
                  8'hFF, 8'h79, 8'h12, 8'h31, 8'h23, 8'h59, 8'h00, 8'hFF,
                  8'h33, 8'hFF, 8'h99, 8'hE0, 8'hE4, 8'hE6, 8'h00, 8'h41,
                  8'hFF};
    foreach (rec_bytes[i]) put(rec_bytes[i], 1'b0);
    wait_idle();

    set_offset(-15'sd9999);
    queue_records(100);
    drain_next = 1'b1;
    queue_records(165);
    wait_idle();

    set_offset(15'sd9999);
    out_gaps = 1'b0;
    queue_records(295);
    wait_idle();

    set_offset(15'($urandom_range(0, 19998) - 9999));
    in_gaps = 1'b0;
    queue_records(405);
    wait_idle();

    set_offset(15'sd0);
    in_gaps = 1'b1;
    out_gaps = 1'b1;
    queue_records(465);
    choice = $urandom_range(0, 3);
    case (choice)
      0: put(8'($urandom), 1'b1);
      1: put(erbp_pkg::END_BYTE, 1'b0);
      default: begin
        build_record(1'b0);
        cut = (choice == 2) ? 7 : $urandom_range(1, rec_bytes.size() - 1);
        for (int i = 0; i < cut; i++) put(rec_bytes[i], 1'b0);
        put(8'($urandom), 1'b1);
      end
    endcase
    put(erbp_pkg::END_BYTE, 1'b0);
    put(8'($urandom), 1'b1);
    put(8'($urandom), 1'b0);
    wait_idle();

    if (expected_fields.size() != 0)
      report_error($sformatf("%0d field words never arrived", expected_fields.size()));
    $display("covered %0d stream words, %0d field words, %0d records, %0d offset writes",
             words_sent, fields_checked, records_seen, offsets_written);
    $display("record stream ended by terminator kind %0d after %0d cycles",
             choice, cycle_count);
    if (error_count == 0) begin
      $display("exposure_record_byte_parser_test: clean");
    end else begin
      $display("exposure_record_byte_parser_test: errors");
    end
    $finish;
  end

endmodule
